// ===== hdl/bcoef_pkg.sv =====
// Shared types and constants for the binomial coefficient engine.
// No dependencies; every other file refers to it by scoped names.
package bcoef_pkg;

   localparam int MAX_N     = 63;
   localparam int ROW_DEPTH = MAX_N + 1;
   localparam int IDX_W     = $clog2(ROW_DEPTH);
   localparam int FIELD_W   = 6;
   localparam int VALUE_W   = 64;
   localparam int COEF_W    = 60;

   typedef logic [FIELD_W-1:0] field_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COEF_W-1:0]  coef_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ROW_DEPTH-1:0] mask_type;

   // Broadcast from the sequencer to every cell of the row.
   typedef struct packed {
      logic clear;   // load seed value (start of a beat)
      logic step;    // one Pascal row update this cycle
   } cell_ctrl_type;

   typedef logic [1:0] state_type;
   localparam state_type ST_IDLE   = 2'd0;
   localparam state_type ST_RUN    = 2'd1;
   localparam state_type ST_FINISH = 2'd2;

endpackage

// ===== hdl/bcoef_req_if.sv =====
// Request channel: valid/ready handshake carrying n and k.
// Depends on bcoef_pkg.
interface bcoef_req_if;
   logic                 valid;
   logic                 ready;
   bcoef_pkg::field_type row_number;
   bcoef_pkg::field_type choose_count;

   modport source (output valid, output row_number, output choose_count, input ready);
   modport sink   (input valid, input row_number, input choose_count, output ready);
endinterface

// ===== hdl/bcoef_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the coefficient.
// Depends on bcoef_pkg.
interface bcoef_rsp_if;
   logic                valid;
   logic                ready;
   bcoef_pkg::coef_type coefficient;

   modport source (output valid, output coefficient, input ready);
   modport sink   (input valid, input coefficient, output ready);
endinterface

// ===== hdl/bcoef_cell.sv =====
// One entry of the Pascal row: holds its value and adds its left neighbor on a step when selected.
// Depends on bcoef_pkg.
module bcoef_cell (
   input  logic                    clock,
   input  bcoef_pkg::cell_ctrl_type ctrl,
   input  logic                    seed,
   input  logic                    sel,
   input  bcoef_pkg::value_type    left_value,
   output bcoef_pkg::value_type    value
);

   bcoef_pkg::value_type value_ff;
   bcoef_pkg::value_type value_in;

   always_comb begin
      value_in = value_ff;
      priority if (ctrl.clear) begin
         value_in = {{(bcoef_pkg::VALUE_W-1){1'b0}}, seed};
      end else if (ctrl.step && sel) begin
         value_in = value_ff + left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hdl/binomial_coefficient_engine_core.sv =====
// Binomial coefficient engine: C(n,k) from a row of Pascal-triangle cells.
// One request is in flight at a time: after the request beat the sequencer steps
// through RUN (skipped when k > n or n = 0) and FINISH, which loads the response
// register once the output is free. The row advances one triangle row per cycle in
// RUN. The response register lets the next request in while a result waits. Reset
// (synchronous) returns the sequencer to idle and drops the response; the row itself is not reset.
module binomial_coefficient_engine_core (
   input logic         clock,
   input logic         reset,
   bcoef_req_if.sink   req,
   bcoef_rsp_if.source rsp
);

   bcoef_pkg::state_type state_ff, state_in;
   bcoef_pkg::field_type n_ff, n_in;
   bcoef_pkg::field_type k_ff, k_in;
   bcoef_pkg::field_type iter_ff, iter_in;
   bcoef_pkg::mask_type  imask_ff, imask_in;
   bcoef_pkg::mask_type  kmask_ff, kmask_in;
   logic                 zero_ff, zero_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bcoef_pkg::coef_type  coef_ff, coef_in;

   bcoef_pkg::cell_ctrl_type cell_ctrl;
   bcoef_pkg::mask_type      run_mask;
   bcoef_pkg::value_type     row_value [bcoef_pkg::ROW_DEPTH];
   bcoef_pkg::value_type     picked;

   logic accept;
   logic out_free;
   logic load;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load     = (state_ff == bcoef_pkg::ST_FINISH) && out_free;
   assign run_mask = imask_ff & kmask_ff;

   assign cell_ctrl.clear = accept;
   assign cell_ctrl.step  = (state_ff == bcoef_pkg::ST_RUN);

   genvar j;
   generate
      for (j = 0; j < bcoef_pkg::ROW_DEPTH; j++) begin : g_cell
         bcoef_pkg::value_type left_value;
         if (j == 0) begin : g_head
            assign left_value = '0;
         end else begin : g_body
            assign left_value = row_value[j-1];
         end
         bcoef_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .seed       (j == 0),
            .sel        (run_mask[j]),
            .left_value (left_value),
            .value      (row_value[j])
         );
      end
   endgenerate

   // k > n and out-of-range n are caught at the request; zero_ff masks the row.
   assign picked = row_value[bcoef_pkg::IDX_W'(k_ff)];

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      iter_in  = iter_ff;
      imask_in = imask_ff;
      kmask_in = kmask_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         bcoef_pkg::ST_IDLE: begin
            if (accept) begin
               n_in     = req.row_number;
               k_in     = req.choose_count;
               iter_in  = bcoef_pkg::FIELD_W'(1);
               imask_in = '0;
               imask_in[1] = 1'b1;
               for (int b = 0; b < bcoef_pkg::ROW_DEPTH; b++) begin
                  kmask_in[b] = (b != 0) && (b <= int'(req.choose_count));
               end
               zero_in  = (int'(req.row_number) > bcoef_pkg::MAX_N) ||
                          (req.choose_count > req.row_number);
               if (zero_in || (req.row_number == '0)) begin
                  state_in = bcoef_pkg::ST_FINISH;
               end else begin
                  state_in = bcoef_pkg::ST_RUN;
               end
            end
         end
         bcoef_pkg::ST_RUN: begin
            iter_in  = iter_ff + bcoef_pkg::FIELD_W'(1);
            // active window widens by one entry per row, capped by kmask
            imask_in = {imask_ff[bcoef_pkg::ROW_DEPTH-2:0], 1'b0} | imask_ff;
            if (iter_ff == n_ff) begin
               state_in = bcoef_pkg::ST_FINISH;
            end
         end
         bcoef_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = bcoef_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcoef_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      coef_in      = coef_ff;
      priority if (load) begin
         rsp_valid_in = 1'b1;
         coef_in      = zero_ff ? '0 : picked[bcoef_pkg::COEF_W-1:0];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcoef_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      k_ff     <= k_in;
      iter_ff  <= iter_in;
      imask_ff <= imask_in;
      kmask_ff <= kmask_in;
      zero_ff  <= zero_in;
      coef_ff  <= coef_in;
   end

   assign req.ready       = (state_ff == bcoef_pkg::ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.coefficient = coef_ff;

endmodule

// ===== hdl/bcoef_checker.sv =====
// Port-level checks for binomial_coefficient_engine_core, attached by bind.
// Depends on bcoef_pkg and the top level's port names.
module bcoef_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input bcoef_pkg::field_type req_row_number,
   input bcoef_pkg::field_type req_choose_count,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bcoef_pkg::coef_type  rsp_coefficient
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken while busy");

   // n = 0 and k = 0 with a free output: C(0,0) = 1
   a_row_zero: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && (req_row_number == '0) && (req_choose_count == '0)
      |-> ##2 (rsp_valid && (rsp_coefficient == bcoef_pkg::COEF_W'(1))))
      else $error("C(0,0) not returned as 1");

   // k above n with a free output: the response carries zero
   a_k_above_n: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && (req_choose_count > req_row_number)
      |-> ##2 (rsp_valid && (rsp_coefficient == '0)))
      else $error("k > n did not give zero");

endmodule

bind binomial_coefficient_engine_core bcoef_checker u_bcoef_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_row_number   (req.row_number),
   .req_choose_count (req.choose_count),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_coefficient  (rsp.coefficient)
);

// ===== sim/binomial_coefficient_engine_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for binomial_coefficient_engine_core: drives n,k beats,
// predicts C(n,k) with a Pascal-row walk and checks every response beat in order.
// Depends on bcoef_pkg, bcoef_req_if, bcoef_rsp_if and the core itself.
module binomial_coefficient_engine_core_test;

   localparam int RESET_CYCLES = 12;
   localparam int LONG_HOLD    = 300;   // receiver hold-off for the backpressure test
   localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int TAIL_CYCLES  = 80;    // covers the worst-case latency

   typedef struct {
      bcoef_pkg::field_type n;
      bcoef_pkg::field_type k;
      bcoef_pkg::coef_type  coef;
   } pending_coef_type;

   logic clock;
   logic reset;

   bcoef_req_if req_ch ();
   bcoef_rsp_if rsp_ch ();

   binomial_coefficient_engine_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   pending_coef_type pending_coefs[$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;
   logic          stall_toggle = 1'b0;
   logic          stall_seen;
   int            hold_left;
   int            quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Pascal row walk, 64-bit entries, low 60 bits kept.
   function automatic bcoef_pkg::coef_type predict_coefficient(
      input bcoef_pkg::field_type n,
      input bcoef_pkg::field_type k
   );
      bcoef_pkg::value_type row [bcoef_pkg::ROW_DEPTH];
      int top;
      if (int'(n) > bcoef_pkg::MAX_N || k > n) return '0;
      foreach (row[idx]) row[idx] = '0;
      row[0] = bcoef_pkg::value_type'(1);
      for (int i = 1; i <= int'(n); i++) begin
         top = (i < int'(k)) ? i : int'(k);
         for (int j = top; j > 0; j--) row[j] = row[j] + row[j-1];
      end
      return row[k][bcoef_pkg::COEF_W-1:0];
   endfunction

   // Response ready: long hold on request, otherwise random idling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         stall_seen   <= stall_toggle;
      end else if (stall_toggle != stall_seen) begin
         stall_seen   <= stall_toggle;
         hold_left    <= LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Record each request beat and check each response beat against the oldest one.
   always @(posedge clock) begin : check_beats
      pending_coef_type head;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_coefs.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat, coefficient %0d", $time, rsp_ch.coefficient);
            end else begin
               head = pending_coefs.pop_front();
               if (rsp_ch.coefficient !== head.coef) begin
                  error_count++;
                  $display("%0t: C(%0d,%0d) expected %0d, actual %0d", $time, head.n,
                           head.k, head.coef, rsp_ch.coefficient);
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_coefs.push_back('{req_ch.row_number, req_ch.choose_count,
                                      predict_coefficient(req_ch.row_number,
                                                          req_ch.choose_count)});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Valid stays up between back-to-back beats; only one assignment per edge.
   task automatic send_pair(input bcoef_pkg::field_type n, input bcoef_pkg::field_type k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.row_number   <= n;
      req_ch.choose_count <= k;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input int count);
      bcoef_pkg::field_type n;
      bcoef_pkg::field_type k;
      repeat (count) begin
         n = bcoef_pkg::field_type'($urandom_range(63));
         case ($urandom_range(9))
            0:       k = bcoef_pkg::field_type'($urandom_range(63));  // often k > n
            1:       k = n;
            2:       k = n + bcoef_pkg::field_type'(1);
            3:       k = '0;
            4:       k = n >> 1;
            default: k = bcoef_pkg::field_type'($urandom_range(int'(n)));
         endcase
         send_pair(n, k);
      end
   endtask

   // The edge after the last beat lets the scoreboard record it first.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_coefs.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_pairs();
      int corner_pairs [22][2] = '{
         '{0, 0},  '{0, 1},  '{0, 63}, '{1, 0},  '{1, 1},  '{1, 2},
         '{2, 1},  '{5, 6},  '{63, 0}, '{63, 1}, '{63, 31}, '{63, 32},
         '{63, 62}, '{63, 63}, '{62, 31}, '{62, 63}, '{42, 21}, '{21, 42},
         '{40, 41}, '{60, 30}, '{10, 5}, '{33, 12}
      };
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (corner_pairs[idx])
         send_pair(bcoef_pkg::field_type'(corner_pairs[idx][0]),
                   bcoef_pkg::field_type'(corner_pairs[idx][1]));
      wait_for_results();
   endtask

   task automatic test_busy_receiver();
      send_idle_pct = 9;
      recv_idle_pct = 59;
      send_random(78);
   endtask

   task automatic test_busy_sender();
      send_idle_pct = 59;
      recv_idle_pct = 9;
      send_random(78);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(78);
      wait_for_results();
   endtask

   // Receiver holds off while requests keep coming; the core must stall its input.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_toggle <= ~stall_toggle;
      send_random(12);
      wait_for_results();
   endtask

   // Sender goes quiet until everything outstanding has come back.
   task automatic test_drain_pause();
      send_idle_pct = 20;
      recv_idle_pct = 30;
      repeat (4) begin
         send_random(3);
         wait_for_results();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.row_number   = '0;
      req_ch.choose_count = '0;
      rsp_ch.ready        = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_pairs();
      test_busy_receiver();
      test_busy_sender();
      test_full_rate();
      test_output_backpressure();
      test_drain_pause();

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_coefs.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
